>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/cam_pkg.sv
// Package with widths, constants, the arctangent table and the command types.
`default_nettype none

package cam_pkg;

  localparam int ITERATIONS    = 24;
  localparam int FRACTION_BITS = 20;

  localparam int IN_W   = 21;
  localparam int OUT_W  = 20;
  localparam int DATA_W = IN_W + FRACTION_BITS + 3;
  localparam int Z_W    = 30;
  localparam int ABS_W  = Z_W - 1;
  localparam int ANG_W  = OUT_W + 1;
  localparam int CNT_W  = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
  localparam int TBL_N  = 24;
  localparam int TBL_IDX_W = $clog2(TBL_N);

  localparam int QUARTER_UDEG  = 90000000;
  localparam int FULL_MDEG     = 360000;
  localparam int UDEG_PER_MDEG = 1000;

  localparam int RECIP_SHIFT = 38;
  localparam longint RECIP_VAL =
    ((64'sd1 <<< RECIP_SHIFT) + UDEG_PER_MDEG - 1) / UDEG_PER_MDEG;
  localparam int RECIP_W = $clog2(RECIP_VAL + 1);
  localparam int PROD_W  = ABS_W + RECIP_W;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [CNT_W-1:0] idx;
    logic             mul;
    logic             fin;
  } cam_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } cam_sts_t;

  function automatic logic signed [Z_W-1:0] atan_udeg(input logic [TBL_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(45000000);
      5'd1:    v = Z_W'(26565051);
      5'd2:    v = Z_W'(14036243);
      5'd3:    v = Z_W'(7125016);
      5'd4:    v = Z_W'(3576334);
      5'd5:    v = Z_W'(1789911);
      5'd6:    v = Z_W'(895174);
      5'd7:    v = Z_W'(447614);
      5'd8:    v = Z_W'(223811);
      5'd9:    v = Z_W'(111906);
      5'd10:   v = Z_W'(55953);
      5'd11:   v = Z_W'(27976);
      5'd12:   v = Z_W'(13988);
      5'd13:   v = Z_W'(6994);
      5'd14:   v = Z_W'(3497);
      5'd15:   v = Z_W'(1748);
      5'd16:   v = Z_W'(874);
      5'd17:   v = Z_W'(437);
      5'd18:   v = Z_W'(218);
      5'd19:   v = Z_W'(109);
      5'd20:   v = Z_W'(55);
      5'd21:   v = Z_W'(27);
      5'd22:   v = Z_W'(14);
      5'd23:   v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cam_ctrl.sv
// Controller state machine that sequences load, iterations, scaling and output.
`default_nettype none
`include "assert_macros.svh"

module cam_ctrl import cam_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire cam_sts_t sts,
  output cam_cmd_t      cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_ITER, ST_MUL, ST_FIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;

  always_comb begin
    in_stall = (state != ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.step = (state == ST_ITER);
    cmd.idx  = count;
    cmd.mul  = (state == ST_MUL);
    cmd.fin  = (state == ST_FIN) && !sts.out_blocked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          count <= '0;
          if (in_valid) begin
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (count == CNT_W'(ITERATIONS - 1)) begin
            state <= ST_MUL;
          end else begin
            count <= count + 1'b1;
          end
        end
        ST_MUL: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!sts.out_blocked) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && !in_stall, state == ST_ITER && count == '0)
  `ASSERT_IMPLY(a_fin_unblocked, clk, rst, cmd.fin, !sts.out_blocked && state == ST_FIN)

endmodule

`default_nettype wire

>>> hw/rtl/cam_dpath.sv
// Datapath with the vectoring registers, the milli-degree scaling and the output word.
`default_nettype none
`include "assert_macros.svh"

module cam_dpath import cam_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_wr_data,
  input  wire logic signed [IN_W-1:0]  y_value,
  input  wire logic signed [IN_W-1:0]  x_value,
  input  wire cam_cmd_t                cmd,
  output cam_sts_t                     sts,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      angle
);

  logic                     wrap_positive;
  logic signed [DATA_W-1:0] xr;
  logic signed [DATA_W-1:0] yr;
  logic signed [Z_W-1:0]    zr;
  logic                     zero_in;
  logic [PROD_W-1:0]        prod;
  logic                     z_neg;

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic signed [DATA_W-1:0] x_init;
  logic signed [DATA_W-1:0] y_init;
  logic signed [Z_W-1:0]    z_init;
  logic signed [DATA_W-1:0] x_sh;
  logic signed [DATA_W-1:0] y_sh;
  logic signed [Z_W-1:0]    step_angle;
  logic [ABS_W-1:0]         z_abs;
  logic signed [ANG_W-1:0]  quot;
  logic signed [ANG_W-1:0]  ang_trunc;
  logic signed [ANG_W-1:0]  ang_final;

  assign sts.out_blocked = out_valid && out_stall;

  // A vector in the left half plane is turned a quarter turn into the right half.
  always_comb begin
    xs     = DATA_W'(x_value) <<< FRACTION_BITS;
    ys     = DATA_W'(y_value) <<< FRACTION_BITS;
    x_init = xs;
    y_init = ys;
    z_init = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x_init = ys;
        y_init = -xs;
        z_init = Z_W'(QUARTER_UDEG);
      end else begin
        x_init = -ys;
        y_init = xs;
        z_init = -Z_W'(QUARTER_UDEG);
      end
    end
  end

  always_comb begin
    x_sh       = xr >>> cmd.idx;
    y_sh       = yr >>> cmd.idx;
    step_angle = atan_udeg(TBL_IDX_W'(cmd.idx));
    z_abs      = zr[Z_W-1] ? ABS_W'(-zr) : ABS_W'(zr);
  end

  // Truncation toward zero: scale the magnitude, restore the sign; then zero-input and wrap fixups.
  always_comb begin
    quot      = ANG_W'(prod >> RECIP_SHIFT);
    ang_trunc = z_neg ? -quot : quot;
    ang_final = ang_trunc;
    if (zero_in) begin
      ang_final = '0;
    end else if (wrap_positive && ang_trunc < 0) begin
      ang_final = ang_trunc + ANG_W'(FULL_MDEG);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_positive <= 1'b1;
    end else if (cfg_wr_en) begin
      wrap_positive <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xr      <= x_init;
      yr      <= y_init;
      zr      <= z_init;
      zero_in <= (x_value == '0) && (y_value == '0);
    end else if (cmd.step) begin
      if (yr >= 0) begin
        xr <= xr + y_sh;
        yr <= yr - x_sh;
        zr <= zr + step_angle;
      end else begin
        xr <= xr - y_sh;
        yr <= yr + x_sh;
        zr <= zr - step_angle;
      end
    end
    if (cmd.mul) begin
      prod  <= PROD_W'(z_abs) * PROD_W'(RECIP_VAL);
      z_neg <= zr[Z_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      angle <= OUT_W'(ang_final);
    end
  end

  `ASSERT_IMPLY(a_zero_result, clk, rst, $past(cmd.fin) && $past(zero_in), angle == '0)
  `ASSERT_IMPLY(a_wrap_nonneg, clk, rst, $past(cmd.fin) && $past(wrap_positive), !angle[OUT_W-1])

endmodule

`default_nettype wire

>>> hw/rtl/cordic_atan2_millidegree.sv
// Top level of the four-quadrant CORDIC arctangent in milli-degrees.
//
//   channel | direction | handshake           | payload
//   in      | to block  | in_valid / in_stall | y_value, x_value (21-bit signed)
//   out     | from block| out_valid/out_stall | angle (20-bit)
//   cfg     | to block  | cfg_wr_en           | cfg_wr_data (wrap_positive)
//
// A word is accepted in the idle state, where the operands are loaded with the
// quadrant turn. Its result comes from 24 vectoring steps through one shared
// add-and-shift unit, a multiply for the milli-degree scaling and the output
// register. A new word is taken in the cycle after the result is written, so
// the block never takes a new word before the last one is through. A stalled
// output holds the sequencer in its last state. Reset is synchronous;
// wrap_positive resets to 1.
`default_nettype none

module cordic_atan2_millidegree import cam_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [IN_W-1:0] y_value,
  input  wire logic signed [IN_W-1:0] x_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [OUT_W-1:0]     angle
);

  cam_cmd_t cmd;
  cam_sts_t sts;

  cam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cam_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .y_value     (y_value),
    .x_value     (x_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .angle       (angle)
  );

endmodule

`default_nettype wire
